// File: hdl/hrd_pkg.sv
package hrd_pkg;

    localparam logic [2:0] PH_STATUS   = 3'd0;
    localparam logic [2:0] PH_HEADERS  = 3'd1;
    localparam logic [2:0] PH_BODY     = 3'd2;
    localparam logic [2:0] PH_CSIZE    = 3'd3;
    localparam logic [2:0] PH_CBREAK   = 3'd4;
    localparam logic [2:0] PH_FINISHED = 3'd5;
    localparam logic [2:0] PH_REDIRECT = 3'd6;
    localparam logic [2:0] PH_ERROR    = 3'd7;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_VERSION = 2'd1;
    localparam logic [1:0] ERR_STATUS  = 2'd2;
    localparam logic [1:0] ERR_ZEROLEN = 2'd3;

    localparam logic [4:0] FL_V10 = 5'b00001;
    localparam logic [4:0] FL_V11 = 5'b00010;
    localparam logic [4:0] FL_LOC = 5'b00100;
    localparam logic [4:0] FL_CL  = 5'b01000;
    localparam logic [4:0] FL_CHK = 5'b10000;

    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_NUL = 8'h00;

    typedef logic [7:0] t_byte;

    function automatic t_byte to_lower(input t_byte c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic is_space(input t_byte c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B || c == 8'h0C || c == 8'h0D;
    endfunction

    function automatic logic is_blank(input t_byte c);
        return c == 8'h20 || c == 8'h09;
    endfunction

    // 99 when the byte is not a hex digit
    function automatic logic [6:0] digit_of(input t_byte c);
        t_byte l;
        l = to_lower(c);
        if (c >= 8'h30 && c <= 8'h39) return 7'(c - 8'h30);
        if (l >= 8'h61 && l <= 8'h66) return 7'(l - 8'h61 + 8'd10);
        return 7'd99;
    endfunction

    function automatic t_byte pat_ver(input logic [3:0] p, input logic v11);
        case (p)
            4'd0: return "H";
            4'd1: return "T";
            4'd2: return "T";
            4'd3: return "P";
            4'd4: return "/";
            4'd5: return "1";
            4'd6: return ".";
            4'd7: return v11 ? "1" : "0";
            default: return 8'h00;
        endcase
    endfunction

    function automatic t_byte pat_loc(input logic [3:0] p);
        case (p)
            4'd0: return "l";
            4'd1: return "o";
            4'd2: return "c";
            4'd3: return "a";
            4'd4: return "t";
            4'd5: return "i";
            4'd6: return "o";
            4'd7: return "n";
            4'd8: return ":";
            4'd9: return " ";
            default: return 8'h00;
        endcase
    endfunction

    function automatic t_byte pat_cl(input logic [3:0] p);
        case (p)
            4'd0:  return "c";
            4'd1:  return "o";
            4'd2:  return "n";
            4'd3:  return "t";
            4'd4:  return "e";
            4'd5:  return "n";
            4'd6:  return "t";
            4'd7:  return "-";
            4'd8:  return "l";
            4'd9:  return "e";
            4'd10: return "n";
            4'd11: return "g";
            4'd12: return "t";
            4'd13: return "h";
            4'd14: return ":";
            default: return 8'h00;
        endcase
    endfunction

    function automatic t_byte pat_chk(input logic [4:0] p);
        case (p)
            5'd0:  return "t";
            5'd1:  return "r";
            5'd2:  return "a";
            5'd3:  return "n";
            5'd4:  return "s";
            5'd5:  return "f";
            5'd6:  return "e";
            5'd7:  return "r";
            5'd8:  return "-";
            5'd9:  return "e";
            5'd10: return "n";
            5'd11: return "c";
            5'd12: return "o";
            5'd13: return "d";
            5'd14: return "i";
            5'd15: return "n";
            5'd16: return "g";
            5'd17: return ":";
            5'd18: return " ";
            5'd19: return "c";
            5'd20: return "h";
            5'd21: return "u";
            5'd22: return "n";
            5'd23: return "k";
            5'd24: return "e";
            5'd25: return "d";
            default: return 8'h00;
        endcase
    endfunction

endpackage

// File: hdl/http_response_deframer.sv
// HTTP/1.0 and HTTP/1.1 response deframer. One item per clock while the output does not stall:
// s_axis_tdata carries a received byte and s_axis_tuser high starts a new response instead. Every
// input item yields one result item in the next cycle, held in the output register; the next item
// is taken in the same cycle the result leaves or while the output register is empty, so the block
// runs at one item per cycle unless m_axis_tready holds it back, with a combinational header match
// and length accumulate. Results carry the body byte (m_axis_tdata bit 0 valid, bits 8:1 byte), the
// phase, error kind and status code; m_axis_tlast marks the byte that ends a known content length.
// i_keep_alive_we writes the keep-alive bit; with it clear the finished phase also raises close.
module http_response_deframer #(
    parameter int MAX_LINE    = 256,
    parameter int LENGTH_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_keep_alive_we,
    input  logic        i_keep_alive,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // body_valid, body_byte[7:0], phase[2:0], error_kind[1:0], response_code[10:0],
    // close_connection, zero fill
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast    // body_last
);
    import hrd_pkg::*;

    localparam int PW = $clog2(MAX_LINE);
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_LINE - 1);
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    logic                   r_keep;
    logic [2:0]             r_phase;
    logic [PW-1:0]          r_pos;
    logic [4:0]             r_flags;
    logic [LENGTH_BITS-1:0] r_acc;
    logic [2:0]             r_nst;
    logic                   r_neg;
    logic [1:0]             r_cnt;
    logic                   r_known;
    logic [LENGTH_BITS-1:0] r_body;
    logic [LENGTH_BITS-1:0] r_chunk;
    logic                   r_chunked;
    logic [10:0]            r_code;
    logic                   r_cr;
    logic [1:0]             r_err;

    logic [2:0]             n_phase;
    logic [PW-1:0]          n_pos;
    logic [4:0]             n_flags;
    logic [LENGTH_BITS-1:0] n_acc;
    logic [2:0]             n_nst;
    logic                   n_neg;
    logic [1:0]             n_cnt;
    logic                   n_known;
    logic [LENGTH_BITS-1:0] n_body;
    logic [LENGTH_BITS-1:0] n_chunk;
    logic                   n_chunked;
    logic [10:0]            n_code;
    logic                   n_cr;
    logic [1:0]             n_err;
    logic                   n_bv;
    logic                   n_last;

    logic                   r_ov;
    logic [31:0]            r_od;
    logic                   r_ol;

    logic accept;
    assign s_axis_tready = !r_ov || m_axis_tready;
    assign accept = s_axis_tvalid && s_axis_tready;

    t_byte                  c;
    t_byte                  cl;
    logic [6:0]             d;
    logic                   lf_end;
    logic [PW-1:0]          eff;
    logic [LENGTH_BITS-1:0] dext;
    logic [LENGTH_BITS-1:0] mul10;
    logic [LENGTH_BITS-1:0] mul16;
    logic [LENGTH_BITS+4:0] wide10;
    logic [LENGTH_BITS+4:0] wide16;
    logic [LENGTH_BITS-1:0] vchunk;
    logic [10:0]            acc11;
    logic [2:0]             st;

    always_comb begin
        c = s_axis_tdata;
        cl = to_lower(c);
        d = digit_of(c);
        dext = LENGTH_BITS'(d[3:0]);
        wide10 = {5'd0, r_acc} * 10 + {5'd0, dext};
        wide16 = {r_acc, 4'd0} + {5'd0, dext};
        mul10 = (wide10 > {5'd0, LEN_MAX}) ? LEN_MAX : wide10[LENGTH_BITS-1:0];
        mul16 = (wide16 > {5'd0, LEN_MAX}) ? LEN_MAX : wide16[LENGTH_BITS-1:0];
        lf_end = c == CH_LF;
        eff = (lf_end && r_cr && r_pos != '0) ? r_pos - 1'b1 : r_pos;
        vchunk = r_neg ? (LENGTH_BITS'(0) - r_acc) : r_acc;
        acc11 = r_acc[10:0];

        n_phase = r_phase;   n_pos = r_pos;     n_flags = r_flags;
        n_acc = r_acc;       n_nst = r_nst;     n_neg = r_neg;
        n_cnt = r_cnt;       n_known = r_known; n_body = r_body;
        n_chunk = r_chunk;   n_chunked = r_chunked;
        n_code = r_code;     n_cr = r_cr;       n_err = r_err;
        n_bv = 1'b0;         n_last = 1'b0;
        st = r_nst;

        if (s_axis_tuser) begin
            n_phase = PH_STATUS; n_pos = '0; n_flags = '1; n_acc = '0; n_nst = '0;
            n_neg = 1'b0; n_cnt = '0; n_cr = 1'b0; n_known = 1'b0; n_body = '0;
            n_chunk = '0; n_chunked = 1'b0; n_code = '0; n_err = ERR_NONE;
        end else if (r_phase == PH_BODY) begin
            n_bv = 1'b1;
            if (r_known && r_body != '0) begin
                n_body = r_body - 1'b1;
                if (r_body == LENGTH_BITS'(1)) begin
                    n_last = 1'b1;
                    n_phase = PH_FINISHED;
                end
            end
            if (n_phase == PH_BODY && r_chunked && r_chunk != '0) begin
                n_chunk = r_chunk - 1'b1;
                if (r_chunk == LENGTH_BITS'(1)) n_phase = PH_CBREAK;
            end
        end else if (r_phase <= PH_CBREAK) begin
            if (c == CH_LF || c == CH_NUL) begin
                case (r_phase)
                    PH_STATUS: begin
                        if (r_pos < PW'(8) || (r_flags & (FL_V10 | FL_V11)) == '0) begin
                            n_phase = PH_ERROR; n_err = ERR_VERSION;
                        end else if (r_nst == 3'd4 || r_nst == 3'd5) begin
                            n_code = r_neg ? 11'(-acc11) : acc11;
                            n_phase = PH_HEADERS; n_known = 1'b0; n_body = '0;
                            n_chunked = 1'b0;
                        end else begin
                            n_phase = PH_ERROR; n_err = ERR_STATUS;
                        end
                    end
                    PH_HEADERS: begin
                        if (eff == '0) begin
                            if (r_known && r_body == '0) begin
                                n_phase = PH_ERROR; n_err = ERR_ZEROLEN;
                            end else begin
                                n_phase = r_chunked ? PH_CSIZE : PH_BODY;
                            end
                        end else if ((r_flags & FL_LOC) != '0 && eff >= PW'(10)) begin
                            if (r_code == 11'd301 || r_code == 11'd302 || r_code == 11'd307
                                || r_code == 11'd308) n_phase = PH_REDIRECT;
                        end else if ((r_flags & FL_CL) != '0 && eff >= PW'(15)) begin
                            if (r_neg && r_acc != '0) begin
                                n_known = 1'b0; n_body = '0;
                            end else begin
                                n_known = 1'b1; n_body = r_acc;
                            end
                        end else if ((r_flags & FL_CHK) != '0 && eff == PW'(26)) begin
                            n_chunked = 1'b1;
                        end
                    end
                    PH_CSIZE: begin
                        if (vchunk != '0) begin
                            n_chunk = vchunk; n_phase = PH_BODY;
                        end else begin
                            n_phase = PH_FINISHED;
                        end
                    end
                    PH_CBREAK: n_phase = PH_CSIZE;
                    default: n_phase = r_phase;
                endcase
                n_pos = '0; n_flags = '1; n_acc = '0; n_nst = '0; n_neg = 1'b0;
                n_cnt = '0; n_cr = 1'b0;
            end else begin
                if (r_pos < POS_MAX) begin
                    n_pos = r_pos + 1'b1;
                    if (r_phase == PH_STATUS) begin
                        if (r_pos < PW'(8)) begin
                            if (c != pat_ver(r_pos[3:0], 1'b0)) n_flags = n_flags & ~FL_V10;
                            if (c != pat_ver(r_pos[3:0], 1'b1)) n_flags = n_flags & ~FL_V11;
                        end else begin
                            // status code: blank, more blanks, sign, up to three characters
                            if (st == 3'd1 && !is_blank(c)) st = 3'd2;
                            case (st)
                                3'd0: n_nst = is_blank(c) ? 3'd1 : 3'd6;
                                3'd1: n_nst = 3'd1;
                                3'd2: begin
                                    n_nst = 3'd2;
                                    if (is_space(c)) n_nst = 3'd2;
                                    else if (c == "+" || c == "-") begin
                                        n_neg = c == "-"; n_cnt = 2'd1; n_nst = 3'd3;
                                    end else if (d < 7'd10) begin
                                        n_acc = dext; n_cnt = 2'd1; n_nst = 3'd4;
                                    end else n_nst = 3'd6;
                                end
                                3'd3: begin
                                    if (d < 7'd10) begin
                                        n_acc = dext; n_cnt = 2'd2; n_nst = 3'd4;
                                    end else n_nst = 3'd6;
                                end
                                3'd4: begin
                                    if (d < 7'd10) begin
                                        n_acc = LENGTH_BITS'(r_acc[9:0] * 10) + dext;
                                        n_cnt = r_cnt + 1'b1;
                                        if (r_cnt == 2'd2) n_nst = 3'd5;
                                    end else n_nst = 3'd5;
                                end
                                default: n_nst = r_nst;
                            endcase
                        end
                    end else if (r_phase == PH_HEADERS || r_phase == PH_CSIZE) begin
                        if (r_phase == PH_HEADERS) begin
                            if (r_pos < PW'(10) && cl != pat_loc(r_pos[3:0]))
                                n_flags = n_flags & ~FL_LOC;
                            if (r_pos < PW'(15) && cl != pat_cl(r_pos[3:0]))
                                n_flags = n_flags & ~FL_CL;
                            if (r_pos < PW'(26) && cl != pat_chk(r_pos[4:0]))
                                n_flags = n_flags & ~FL_CHK;
                        end
                        if ((r_phase == PH_CSIZE)
                            || (r_pos >= PW'(15) && (r_flags & FL_CL) != '0)) begin
                            if (st == 3'd0 && !is_space(c)) begin
                                if (c == "+" || c == "-") begin
                                    n_neg = c == "-"; n_nst = 3'd1;
                                end else st = 3'd1;
                            end
                            if (st == 3'd1) begin
                                if (d < ((r_phase == PH_CSIZE) ? 7'd16 : 7'd10)) begin
                                    n_acc = dext;
                                    n_nst = (r_phase == PH_CSIZE && d == 7'd0) ? 3'd2 : 3'd3;
                                end else n_nst = 3'd4;
                            end else if (st == 3'd2 && (c == "x" || c == "X")) begin
                                n_nst = 3'd3;
                            end else if (st == 3'd2 || st == 3'd3) begin
                                if (d < ((r_phase == PH_CSIZE) ? 7'd16 : 7'd10)) begin
                                    n_acc = (r_phase == PH_CSIZE) ? mul16 : mul10;
                                    n_nst = 3'd3;
                                end else n_nst = 3'd4;
                            end
                        end
                    end
                end
                n_cr = c == CH_CR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= 1'b0;
            r_phase <= PH_STATUS; r_pos <= '0; r_flags <= '1; r_acc <= '0; r_nst <= '0;
            r_neg <= 1'b0; r_cnt <= '0; r_known <= 1'b0; r_body <= '0; r_chunk <= '0;
            r_chunked <= 1'b0; r_code <= '0; r_cr <= 1'b0; r_err <= ERR_NONE;
            r_ov <= 1'b0;
        end else begin
            if (i_keep_alive_we) r_keep <= i_keep_alive;
            if (accept) begin
                r_phase <= n_phase; r_pos <= n_pos; r_flags <= n_flags; r_acc <= n_acc;
                r_nst <= n_nst; r_neg <= n_neg; r_cnt <= n_cnt; r_known <= n_known;
                r_body <= n_body; r_chunk <= n_chunk; r_chunked <= n_chunked;
                r_code <= n_code; r_cr <= n_cr; r_err <= n_err;
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // close uses keep_alive held at accept; config changes only while idle is up to the user
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_od <= {6'd0,
                     n_phase == PH_FINISHED && !r_keep,
                     n_code,
                     (n_phase == PH_ERROR) ? n_err : ERR_NONE,
                     n_phase,
                     n_bv ? c : 8'h00,
                     n_bv};
            r_ol <= n_last;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;
    assign m_axis_tlast  = r_ol;

endmodule

// File: hdl/hrd_checker.sv
module hrd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    import hrd_pkg::*;

    // each accepted item shows a result in the next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("item without result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[0] && m_axis_tdata[11:9] == PH_FINISHED)
        else $error("last without finishing body byte");

    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[13:12] != ERR_NONE |-> m_axis_tdata[11:9] == PH_ERROR)
        else $error("error kind outside error phase");

endmodule

bind http_response_deframer hrd_checker u_hrd_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);

// File: test/testbench.sv
module testbench;
    import hrd_pkg::*;

    localparam int          CYCLE_LIMIT = 600000;
    localparam int          LINE_CAP    = 255;
    localparam logic [63:0] LEN_TOP     = 64'hFFFF_FFFF;

    typedef struct {
        logic       act;
        logic [7:0] b;
        bit         typed;
        logic [2:0] tph;
        logic [1:0] ter;
    } t_stim;

    typedef struct {
        logic        bv;
        logic [7:0]  bb;
        logic        bl;
        logic [2:0]  ph;
        logic [1:0]  er;
        logic [10:0] rc;
        logic        cc;
        bit          typed;
        logic [2:0]  tph;
        logic [1:0]  ter;
    } t_resp;

    typedef struct {
        bit         act;
        string      text;
        int         raw;
        bit         typed;
        logic [2:0] ph;
        logic [1:0] er;
    } t_row;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        ka_we = 0;
    logic        ka_val = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tdata = 0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    http_response_deframer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_keep_alive_we(ka_we),
        .i_keep_alive   (ka_val),
        .s_axis_tvalid  (s_tvalid),
        .s_axis_tready  (s_tready),
        .s_axis_tdata   (s_tdata),
        .s_axis_tuser   (s_tuser),
        .m_axis_tvalid  (m_tvalid),
        .m_axis_tready  (m_tready),
        .m_axis_tdata   (m_tdata),
        .m_axis_tlast   (m_tlast)
    );

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    // parser model state
    logic        mk_alive;
    logic [2:0]  mk_phase;
    int unsigned mk_pos;
    logic [4:0]  mk_flags;
    logic [63:0] mk_acc;
    int          mk_stage;
    bit          mk_neg;
    int          mk_conv;
    bit          mk_lknown;
    logic [63:0] mk_body_left;
    logic [63:0] mk_chunk_left;
    bit          mk_chunked;
    int          mk_code;
    bit          mk_prev_cr;
    logic [1:0]  mk_err;

    t_stim byte_q[$];
    t_resp resp_q[$];
    t_stim cur;
    bit    offered = 0;
    bit    hold = 0;
    int    send_idle = 0;
    int    recv_idle = 0;
    int    cycles = 0;
    int    fails = 0;
    int    n_items = 0;
    int    n_body = 0;
    int    n_fin = 0;
    int    n_redir = 0;
    int    n_err = 0;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic bit white(input logic [7:0] c);
        return c == " " || c == 8'h09 || c == CH_LF || c == 8'h0B || c == 8'h0C || c == CH_CR;
    endfunction

    function automatic int hexval(input logic [7:0] c);
        logic [7:0] l;
        l = fold_case(c);
        if (c >= "0" && c <= "9") return c - "0";
        if (l >= "a" && l <= "f") return l - "a" + 10;
        return 99;
    endfunction

    function automatic void clear_line();
        mk_pos = 0;
        mk_flags = 5'h1F;
        mk_acc = 0;
        mk_stage = 0;
        mk_neg = 0;
        mk_conv = 0;
        mk_prev_cr = 0;
    endfunction

    function automatic void clear_parse();
        clear_line();
        mk_phase = PH_STATUS;
        mk_lknown = 0;
        mk_body_left = 0;
        mk_chunk_left = 0;
        mk_chunked = 0;
        mk_code = 0;
        mk_err = ERR_NONE;
    endfunction

    function automatic void match_at(input logic [4:0] fl, input string pat, input logic [7:0] c,
                                     input int unsigned p, input bit fold);
        logic [7:0] t;
        if (p >= pat.len()) return;
        t = pat[p];
        if (fold ? (fold_case(c) != fold_case(t)) : (c != t)) mk_flags &= ~fl;
    endfunction

    function automatic void take_digit(input int d, input int base);
        if (mk_acc > (LEN_TOP - 64'(d)) / 64'(base)) mk_acc = LEN_TOP;
        else mk_acc = mk_acc * 64'(base) + 64'(d);
    endfunction

    // 0 skip blanks, 1 first digit (after any sign), 2 leading zero, 3 digits, 4 stopped
    function automatic void feed_number(input logic [7:0] c, input int base);
        int d;
        d = hexval(c);
        if (mk_stage == 0) begin
            if (white(c)) return;
            if (c == "+" || c == "-") begin
                mk_neg = (c == "-");
                mk_stage = 1;
                return;
            end
            mk_stage = 1;
        end
        if (mk_stage == 1) begin
            if (d < base) begin
                mk_acc = d;
                mk_stage = (base == 16 && d == 0) ? 2 : 3;
            end else mk_stage = 4;
            return;
        end
        if (mk_stage == 2 && (c == "x" || c == "X")) begin
            mk_stage = 3;
            return;
        end
        if (mk_stage == 2 || mk_stage == 3) begin
            if (d < base) begin
                take_digit(d, base);
                mk_stage = 3;
            end else mk_stage = 4;
        end
    endfunction

    // 0 need blank, 1 blanks, 2 spaces, 3 sign, 4 digits, 5 done, 6 failed
    function automatic void feed_status(input logic [7:0] c);
        int d;
        bit blank;
        d = hexval(c);
        blank = (c == " " || c == 8'h09);
        if (mk_stage == 0) begin
            mk_stage = blank ? 1 : 6;
            return;
        end
        if (mk_stage == 1) begin
            if (blank) return;
            mk_stage = 2;
        end
        if (mk_stage == 2) begin
            if (white(c)) return;
            if (c == "+" || c == "-") begin
                mk_neg = (c == "-");
                mk_conv = 1;
                mk_stage = 3;
            end else if (d < 10) begin
                mk_acc = d;
                mk_conv = 1;
                mk_stage = 4;
            end else mk_stage = 6;
            return;
        end
        if (mk_stage == 3) begin
            if (d < 10) begin
                mk_acc = d;
                mk_conv = 2;
                mk_stage = 4;
            end else mk_stage = 6;
            return;
        end
        if (mk_stage == 4) begin
            if (d < 10) begin
                mk_acc = mk_acc * 10 + d;
                mk_conv++;
                if (mk_conv >= 3) mk_stage = 5;
            end else mk_stage = 5;
        end
    endfunction

    function automatic void line_byte(input logic [7:0] c, input int unsigned p);
        if (mk_phase == PH_STATUS) begin
            match_at(FL_V10, "HTTP/1.0", c, p, 0);
            match_at(FL_V11, "HTTP/1.1", c, p, 0);
            if (p >= 8) feed_status(c);
        end else if (mk_phase == PH_HEADERS) begin
            match_at(FL_LOC, "Location: ", c, p, 1);
            match_at(FL_CL, "Content-Length:", c, p, 1);
            match_at(FL_CHK, "Transfer-Encoding: chunked", c, p, 1);
            if (p >= 15 && (mk_flags & FL_CL) != 0) feed_number(c, 10);
        end else if (mk_phase == PH_CSIZE) begin
            feed_number(c, 16);
        end
    endfunction

    function automatic void fail_with(input logic [1:0] k);
        mk_phase = PH_ERROR;
        mk_err = k;
    endfunction

    function automatic void line_done(input bit lf);
        int unsigned eff;
        logic [63:0] v;
        eff = (lf && mk_prev_cr && mk_pos > 0) ? mk_pos - 1 : mk_pos;
        if (mk_phase == PH_STATUS) begin
            if (mk_pos < 8 || (mk_flags & (FL_V10 | FL_V11)) == 0) fail_with(ERR_VERSION);
            else if (mk_stage == 4 || mk_stage == 5) begin
                mk_code = mk_neg ? -int'(mk_acc) : int'(mk_acc);
                mk_phase = PH_HEADERS;
                mk_lknown = 0;
                mk_body_left = 0;
                mk_chunked = 0;
            end else fail_with(ERR_STATUS);
        end else if (mk_phase == PH_HEADERS) begin
            if (eff == 0) begin
                if (mk_lknown && mk_body_left == 0) fail_with(ERR_ZEROLEN);
                else mk_phase = mk_chunked ? PH_CSIZE : PH_BODY;
            end else if ((mk_flags & FL_LOC) != 0 && eff >= 10) begin
                if (mk_code == 301 || mk_code == 302 || mk_code == 307 || mk_code == 308)
                    mk_phase = PH_REDIRECT;
            end else if ((mk_flags & FL_CL) != 0 && eff >= 15) begin
                if (mk_neg && mk_acc != 0) begin
                    mk_lknown = 0;
                    mk_body_left = 0;
                end else begin
                    mk_lknown = 1;
                    mk_body_left = mk_acc;
                end
            end else if ((mk_flags & FL_CHK) != 0 && eff == 26) begin
                mk_chunked = 1;
            end
        end else if (mk_phase == PH_CSIZE) begin
            v = mk_neg ? ((64'd0 - mk_acc) & LEN_TOP) : mk_acc;
            if (v != 0) begin
                mk_chunk_left = v;
                mk_phase = PH_BODY;
            end else mk_phase = PH_FINISHED;
        end else if (mk_phase == PH_CBREAK) begin
            mk_phase = PH_CSIZE;
        end
    endfunction

    function automatic t_resp parse_byte(input logic act, input logic [7:0] c);
        t_resp r;
        r.bv = 0;
        r.bb = 0;
        r.bl = 0;
        if (act) begin
            clear_parse();
        end else if (mk_phase == PH_BODY) begin
            r.bv = 1;
            r.bb = c;
            if (mk_lknown && mk_body_left > 0) begin
                mk_body_left--;
                if (mk_body_left == 0) begin
                    r.bl = 1;
                    mk_phase = PH_FINISHED;
                end
            end
            if (mk_phase == PH_BODY && mk_chunked && mk_chunk_left > 0) begin
                mk_chunk_left--;
                if (mk_chunk_left == 0) mk_phase = PH_CBREAK;
            end
        end else if (mk_phase <= PH_CBREAK) begin
            if (c == CH_LF || c == CH_NUL) begin
                line_done(c == CH_LF);
                clear_line();
            end else begin
                if (mk_pos < LINE_CAP) begin
                    line_byte(c, mk_pos);
                    mk_pos++;
                end
                mk_prev_cr = (c == CH_CR);
            end
        end
        r.ph = mk_phase;
        r.er = (mk_phase == PH_ERROR) ? mk_err : ERR_NONE;
        r.rc = mk_code[10:0];
        r.cc = (mk_phase == PH_FINISHED && !mk_alive);
        r.typed = 0;
        return r;
    endfunction

    // sender: presents queued bytes, predicts each accepted item
    always @(posedge i_clk) begin
        logic v_next;
        t_resp r;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else if (i_rst_n) begin
            v_next = s_tvalid;
            if (s_tvalid && s_tready) begin
                r = parse_byte(cur.act, cur.b);
                r.typed = cur.typed;
                r.tph = cur.tph;
                r.ter = cur.ter;
                resp_q.push_back(r);
                n_items++;
                v_next = 0;
                offered = 0;
            end
            if (!v_next && !hold && byte_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                cur = byte_q.pop_front();
                s_tdata <= cur.b;
                s_tuser <= cur.act;
                v_next = 1;
                offered = 1;
            end
            s_tvalid <= v_next;
        end
    end

    task automatic cmp(input string name, input int e, input int a);
        if (e != a) begin
            $error("%s: expected %0d, got %0d", name, e, a);
            fails++;
        end
    endtask

    // receiver: random stalls, compare each result item
    always @(posedge i_clk) begin
        t_resp w;
        m_tready <= ($urandom_range(99) >= recv_idle);
        if (i_rst_n && m_tvalid && m_tready) begin
            if (resp_q.size() == 0) begin
                $error("result item with nothing expected");
                fails++;
            end else begin
                w = resp_q.pop_front();
                cmp("body_valid", w.bv, m_tdata[0]);
                cmp("body_byte", w.bb, m_tdata[8:1]);
                cmp("body_last", w.bl, m_tlast);
                cmp("phase", w.ph, m_tdata[11:9]);
                cmp("error_kind", w.er, m_tdata[13:12]);
                cmp("response_code", w.rc, m_tdata[24:14]);
                cmp("close_connection", w.cc, m_tdata[25]);
                cmp("zero_fill", 0, m_tdata[31:26]);
                if (w.typed) begin
                    cmp("phase (table)", w.tph, m_tdata[11:9]);
                    cmp("error_kind (table)", w.ter, m_tdata[13:12]);
                end
                n_body += w.bv;
                if (w.ph == PH_FINISHED) n_fin++;
                if (w.ph == PH_REDIRECT) n_redir++;
                if (w.ph == PH_ERROR) n_err++;
            end
        end
    end

    task automatic put(input logic act, input logic [7:0] b);
        t_stim s;
        s.act = act;
        s.b = b;
        s.typed = 0;
        byte_q.push_back(s);
    endtask

    task automatic put_text(input string t, input bit mix_case);
        logic [7:0] c;
        for (int i = 0; i < t.len(); i++) begin
            c = t[i];
            if (mix_case && $urandom_range(1) && c >= "a" && c <= "z") c = c - 8'd32;
            put(0, c);
        end
    endtask

    task automatic put_line(input string t, input bit mix_case);
        int k;
        put_text(t, mix_case);
        k = $urandom_range(9);
        if (k < 5) put_text("\r\n", 0);
        else if (k < 9) put(0, CH_LF);
        else put(0, CH_NUL);
    endtask

    task automatic put_junk(input int n);
        for (int i = 0; i < n; i++) put(0, 8'($urandom));
    endtask

    task automatic wait_idle();
        while (byte_q.size() > 0 || offered || resp_q.size() > 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_keep_alive(input logic v);
        @(posedge i_clk);
        ka_we <= 1;
        ka_val <= v;
        mk_alive = v;
        @(posedge i_clk);
        ka_we <= 0;
    endtask

    // one random response; mostly well formed, some broken or pure noise
    task automatic put_response();
        int kind, n, codes[10];
        string ver, sep;
        codes = '{200, 204, 301, 302, 307, 308, 404, 999, 0, 500};
        kind = $urandom_range(9);
        put(1, 8'($urandom));
        if (kind == 9) begin
            put_junk($urandom_range(20));
            return;
        end
        n = $urandom_range(19);
        ver = (n < 9) ? "HTTP/1.1" : (n < 17) ? "HTTP/1.0" : (n == 17) ? "HTTP/2.0" : "HTTP/1.";
        sep = ($urandom_range(3) == 0) ? "\t" : ($urandom_range(3) == 0) ? "  " : " ";
        n = $urandom_range(19);
        if (kind == 7) put_line($sformatf("%s%s%0d", ver, sep, 301 + $urandom_range(7)), 0);
        else if (n == 0) put_line($sformatf("%s%sabc", ver, sep), 0);
        else if (n == 1) put_line($sformatf("%s200", ver), 0);
        else if (n == 2) put_line($sformatf("%s%s-99", ver, sep), 0);
        else if (n == 3) put_line($sformatf("%s%s+12 OK", ver, sep), 0);
        else put_line($sformatf("%s%s%0d OK", ver, sep, codes[$urandom_range(9)]), 0);
        for (int i = $urandom_range(2); i > 0; i--) begin
            if ($urandom_range(29) == 0) begin
                put_text("x-pad: ", 0);
                put_junk(0);
                for (int j = 0; j < 270; j++) put(0, 8'($urandom_range(32, 126)));
                put(0, CH_LF);
            end else put_line("X-Note: abc", 1);
        end
        if (kind <= 3) begin
            n = $urandom_range(15);
            if (n == 0) put_line("Content-Length: 99999999999", 1);
            else if (n == 1) put_line("content-length: -3", 1);
            else if (n == 2) put_line("Content-Length:+4", 1);
            else put_line($sformatf("Content-Length: %0d", $urandom_range(6)), 1);
            put_line("", 0);
            put_junk($urandom_range(8));
        end else if (kind <= 6) begin
            put_line("Transfer-Encoding: chunked", 1);
            put_line("", 0);
            for (int i = $urandom_range(1, 3); i > 0; i--) begin
                n = $urandom_range(1, 6);
                if ($urandom_range(19) == 0) put_line("-1", 0);
                else if ($urandom_range(1)) put_line($sformatf("0x%0H", n), 0);
                else put_line($sformatf(" %0h;ext", n), 0);
                put_junk(n);
                put_line("", 0);
            end
            put_line("0", 0);
        end else if (kind == 7) begin
            put_line("Location: /next", 1);
            put_junk($urandom_range(4));
        end else begin
            put_line("", 0);
            put_junk($urandom_range(10));
        end
    endtask

    t_row rows[] = '{
        '{1, "", -1, 1, PH_STATUS, ERR_NONE},
        '{0, "X\n", -1, 1, PH_ERROR, ERR_VERSION},
        '{1, "", -1, 1, PH_STATUS, ERR_NONE},
        '{0, "HTTP/1.1 abc\n", -1, 1, PH_ERROR, ERR_STATUS},
        '{1, "", -1, 0, PH_STATUS, ERR_NONE},
        '{0, "HTTP/1.0\t-99\r\n", -1, 1, PH_HEADERS, ERR_NONE},
        '{0, "Content-Length: 0\n", -1, 1, PH_HEADERS, ERR_NONE},
        '{0, "\n", -1, 1, PH_ERROR, ERR_ZEROLEN},
        '{1, "", -1, 0, PH_STATUS, ERR_NONE},
        '{0, "HTTP/1.1 301\n", -1, 1, PH_HEADERS, ERR_NONE},
        '{0, "LOCATION: /a\n", -1, 1, PH_REDIRECT, ERR_NONE},
        '{1, "", -1, 0, PH_STATUS, ERR_NONE},
        '{0, "HTTP/1.1 999\n", -1, 0, PH_STATUS, ERR_NONE},
        '{0, "transfer-encoding: chunked\r\n", -1, 0, PH_STATUS, ERR_NONE},
        '{0, "\r\n", -1, 1, PH_CSIZE, ERR_NONE},
        '{0, "0x2\n", -1, 1, PH_BODY, ERR_NONE},
        '{0, "", 255, 0, PH_STATUS, ERR_NONE},
        '{0, "", 0, 1, PH_CBREAK, ERR_NONE},
        '{0, "\n", -1, 1, PH_CSIZE, ERR_NONE},
        '{0, "0\n", -1, 1, PH_FINISHED, ERR_NONE},
        '{1, "", -1, 0, PH_STATUS, ERR_NONE},
        '{0, "HTTP/1.0 200\n\n", -1, 1, PH_BODY, ERR_NONE}
    };

    initial begin
        t_stim s;
        mk_alive = 0;
        clear_parse();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        set_keep_alive(0);
        foreach (rows[i]) begin
            if (rows[i].act) put(1, 8'hA5);
            else if (rows[i].raw >= 0) put(0, 8'(rows[i].raw));
            else put_text(rows[i].text, 0);
            if (rows[i].typed) begin
                s = byte_q.pop_back();
                s.typed = 1;
                s.tph = rows[i].ph;
                s.ter = rows[i].er;
                byte_q.push_back(s);
            end
        end
        wait_idle();
        for (int p = 0; p < 8; p++) begin
            send_idle = (p % 4 == 1) ? 59 : (p % 4 == 3) ? 17 : 0;
            recv_idle = (p % 4 == 2) ? 59 : (p % 4 == 3) ? 17 : 0;
            set_keep_alive((p % 3) != 0);
            for (int k = 0; k < 130; ) begin
                put_response();
                k += byte_q.size();
                if (p == 2 && k > 90 && !hold) begin
                    // stop feeding until the block has drained completely
                    hold = 1;
                    while (resp_q.size() > 0 || offered) @(posedge i_clk);
                    hold = 0;
                end
                while (byte_q.size() > 0) @(posedge i_clk);
            end
            wait_idle();
        end
        $display("covered %0d items over 8 stall/keep-alive settings: %0d body bytes,",
                 n_items, n_body);
        $display("  finished %0d, redirect %0d, error %0d result items", n_fin, n_redir, n_err);
        if (fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
